// ===== src/rafs_pkg.sv =====
// ----------------------------------------------------------------------------
// rafs_pkg
// types and constants shared by the repose angle flow split block
// ----------------------------------------------------------------------------
package rafs_pkg;

    localparam int unsigned H_W      = 24;
    localparam int unsigned DROP_W   = 25;
    localparam int unsigned W_W      = 40;
    localparam int unsigned SUM_W    = 43;
    localparam int unsigned Q_W      = 17;
    localparam int unsigned THR_A_W  = 32;
    localparam int unsigned THR_D_W  = 33;
    localparam int unsigned CMP_W    = 36;
    localparam int unsigned NDIR     = 8;

    localparam logic [16:0] SQRT2_Q16     = 17'd92682;
    localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;

    localparam logic [12:0] GRID_W_RST    = 13'd256;
    localparam logic [12:0] GRID_H_RST    = 13'd256;
    localparam logic [15:0] TAN_RST       = 16'd2662;
    localparam logic [15:0] CELL_RST      = 16'd256;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_TAN_REPOSE  = 2'd2,
        REG_CELL_SIZE   = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [11:0] cell_x;
        logic [11:0] cell_y;
        logic [23:0] height_center;
        logic [23:0] height_d0;
        logic [23:0] height_d1;
        logic [23:0] height_d2;
        logic [23:0] height_d3;
        logic [23:0] height_d4;
        logic [23:0] height_d5;
        logic [23:0] height_d6;
        logic [23:0] height_d7;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  flow_mask;
        logic [3:0]  flow_count;
        logic [15:0] share_d0;
        logic [15:0] share_d1;
        logic [15:0] share_d2;
        logic [15:0] share_d3;
        logic [15:0] share_d4;
        logic [15:0] share_d5;
        logic [15:0] share_d6;
        logic [15:0] share_d7;
    } t_out_item;

    typedef struct packed {
        logic [7:0]                mask;
        logic [3:0]                count;
        logic [SUM_W-1:0]          sum;
        logic [NDIR-1:0][W_W-1:0]  weight;
    } t_job;

    typedef struct packed {
        logic [7:0]                mask;
        logic [3:0]                count;
        logic [SUM_W-1:0]          sum;
        logic [NDIR-1:0][SUM_W-1:0] rem;
        logic [NDIR-1:0][Q_W-1:0]  quo;
    } t_div;

endpackage

// ===== src/rafs_front.sv =====
// ----------------------------------------------------------------------------
// rafs_front
// configuration registers, neighbour classification, weights and weight sum
// ----------------------------------------------------------------------------
module rafs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    input  rafs_pkg::t_in_item i_data,
    output logic              o_ready,
    output logic              o_job_valid,
    output rafs_pkg::t_job    o_job,
    input  logic              i_job_ready
);

    logic [12:0] r_grid_w;
    logic [12:0] r_grid_h;
    logic [15:0] r_tan;
    logic [15:0] r_cell;
    logic [rafs_pkg::THR_A_W-1:0] r_thr_axis;
    logic [rafs_pkg::THR_D_W-1:0] r_thr_diag;
    logic [1:0]  r_hold;
    logic [48:0] diag_prod;

    logic        r_v1;
    logic [7:0]  r_mask1;
    logic [rafs_pkg::NDIR-1:0][rafs_pkg::W_W-1:0] r_w1;
    logic        r_v2;
    rafs_pkg::t_job r_job2;

    logic        en1;
    logic        en2;
    logic [7:0]  n_mask1;
    logic [rafs_pkg::NDIR-1:0][rafs_pkg::W_W-1:0] n_w1;
    logic [rafs_pkg::SUM_W-1:0] n_sum;
    logic [3:0]  n_count;
    logic [rafs_pkg::NDIR-1:0][rafs_pkg::H_W-1:0] hn;
    logic [rafs_pkg::NDIR-1:0] in_x;
    logic [rafs_pkg::NDIR-1:0] in_y;

    function automatic logic inside_at(input logic [11:0] c, input logic [1:0] d,
                                       input logic [12:0] lim);
        logic r;
        unique case (d)
            2'd0:    r = ({1'b0, c} < lim);
            2'd1:    r = (({1'b0, c} + 13'd1) < lim);
            2'd2:    r = (c != 12'd0) && (({1'b0, c} - 13'd1) < lim);
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // cfg products settle through the r_thr_axis and then r_thr_diag registers after a write
    assign diag_prod = r_thr_axis * rafs_pkg::SQRT2_Q16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= rafs_pkg::GRID_W_RST;
            r_grid_h <= rafs_pkg::GRID_H_RST;
            r_tan    <= rafs_pkg::TAN_RST;
            r_cell   <= rafs_pkg::CELL_RST;
            r_hold   <= 2'd3;
        end else begin
            if (i_cfg_valid) begin
                r_hold <= 2'd3;
                unique case (rafs_pkg::t_cfg_index'(i_cfg_index))
                    rafs_pkg::REG_GRID_WIDTH:  r_grid_w <= i_cfg_data[12:0] & 13'h1FFF;
                    rafs_pkg::REG_GRID_HEIGHT: r_grid_h <= i_cfg_data[12:0];
                    rafs_pkg::REG_TAN_REPOSE:  r_tan    <= i_cfg_data;
                    rafs_pkg::REG_CELL_SIZE:   r_cell   <= i_cfg_data;
                    default:                   r_tan    <= r_tan;
                endcase
            end else if (r_hold != 2'd0) begin
                r_hold <= r_hold - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr_axis <= r_tan * r_cell;
        r_thr_diag <= diag_prod[48:16];
    end

    assign en2     = !r_v2 || i_job_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1 && (r_hold == 2'd0);

    assign hn[0] = i_data.height_d0;
    assign hn[1] = i_data.height_d1;
    assign hn[2] = i_data.height_d2;
    assign hn[3] = i_data.height_d3;
    assign hn[4] = i_data.height_d4;
    assign hn[5] = i_data.height_d5;
    assign hn[6] = i_data.height_d6;
    assign hn[7] = i_data.height_d7;

    // dx code: 0 none, 1 plus, 2 minus
    assign in_x[0] = inside_at(i_data.cell_x, 2'd1, r_grid_w);
    assign in_x[1] = inside_at(i_data.cell_x, 2'd1, r_grid_w);
    assign in_x[2] = inside_at(i_data.cell_x, 2'd0, r_grid_w);
    assign in_x[3] = inside_at(i_data.cell_x, 2'd2, r_grid_w);
    assign in_x[4] = inside_at(i_data.cell_x, 2'd2, r_grid_w);
    assign in_x[5] = inside_at(i_data.cell_x, 2'd2, r_grid_w);
    assign in_x[6] = inside_at(i_data.cell_x, 2'd0, r_grid_w);
    assign in_x[7] = inside_at(i_data.cell_x, 2'd1, r_grid_w);
    assign in_y[0] = inside_at(i_data.cell_y, 2'd0, r_grid_h);
    assign in_y[1] = inside_at(i_data.cell_y, 2'd1, r_grid_h);
    assign in_y[2] = inside_at(i_data.cell_y, 2'd1, r_grid_h);
    assign in_y[3] = inside_at(i_data.cell_y, 2'd1, r_grid_h);
    assign in_y[4] = inside_at(i_data.cell_y, 2'd0, r_grid_h);
    assign in_y[5] = inside_at(i_data.cell_y, 2'd2, r_grid_h);
    assign in_y[6] = inside_at(i_data.cell_y, 2'd2, r_grid_h);
    assign in_y[7] = inside_at(i_data.cell_y, 2'd2, r_grid_h);

    always_comb begin
        logic [rafs_pkg::DROP_W-1:0] drop;
        logic [rafs_pkg::CMP_W-1:0]  scaled;
        logic [rafs_pkg::CMP_W-1:0]  thr;
        logic                        pass;
        n_mask1 = '0;
        n_w1    = '0;
        for (int k = 0; k < rafs_pkg::NDIR; k++) begin
            drop   = {1'b0, i_data.height_center} - {1'b0, hn[k]};
            scaled = {drop[rafs_pkg::H_W-1:0], 12'd0};
            thr    = (k % 2 == 1) ? {3'd0, r_thr_diag} : {4'd0, r_thr_axis};
            pass   = in_x[k] && in_y[k] && (i_data.height_center > hn[k]) && (scaled > thr);
            n_mask1[k] = pass;
            if (pass) begin
                if (k % 2 == 1) begin
                    n_w1[k] = drop[rafs_pkg::H_W-1:0] * rafs_pkg::INV_SQRT2_Q16;
                end else begin
                    n_w1[k] = {drop[rafs_pkg::H_W-1:0], 16'd0};
                end
            end
        end
    end

    always_comb begin
        n_sum   = '0;
        n_count = '0;
        for (int k = 0; k < rafs_pkg::NDIR; k++) begin
            n_sum   = n_sum + {3'd0, r_w1[k]};
            n_count = n_count + {3'd0, r_mask1[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid && o_ready;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_mask1 <= n_mask1;
            r_w1    <= n_w1;
        end
        if (en2) begin
            r_job2.mask   <= r_mask1;
            r_job2.count  <= n_count;
            r_job2.sum    <= n_sum;
            r_job2.weight <= r_w1;
        end
    end

    assign o_job_valid = r_v2;
    assign o_job       = r_job2;

endmodule

// ===== src/rafs_queue.sv =====
// ----------------------------------------------------------------------------
// rafs_queue
// two-entry queue between classification and division
// ----------------------------------------------------------------------------
module rafs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  rafs_pkg::t_job i_push_data,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output rafs_pkg::t_job o_pop_data,
    input  logic           i_pop_ready
);

    rafs_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

// ===== src/rafs_back.sv =====
// ----------------------------------------------------------------------------
// rafs_back
// pipelined restoring division of each weight by the weight sum
// ----------------------------------------------------------------------------
module rafs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  rafs_pkg::t_job      i_job,
    output logic                o_job_ready,
    output logic                o_valid,
    output rafs_pkg::t_out_item o_data,
    input  logic                i_ready
);

    localparam int unsigned NST = rafs_pkg::Q_W;

    logic             r_v  [NST];
    rafs_pkg::t_div   r_st [NST];
    rafs_pkg::t_div   n_st [NST];
    logic             r_ov;
    rafs_pkg::t_out_item r_out;
    logic             en;
    logic [rafs_pkg::NDIR-1:0][15:0] shr;

    assign en          = !r_ov || i_ready;
    assign o_job_ready = en;

    for (genvar s = 0; s < NST; s++) begin : g_st
        localparam int PREV = (s == 0) ? 0 : s - 1;

        always_comb begin
            logic [rafs_pkg::SUM_W:0] rin;
            logic [rafs_pkg::SUM_W:0] dd;
            logic                     ge;
            logic [rafs_pkg::SUM_W:0] diff;
            if (s == 0) begin
                n_st[s].mask  = i_job.mask;
                n_st[s].count = i_job.count;
                n_st[s].sum   = i_job.sum;
            end else begin
                n_st[s].mask  = r_st[PREV].mask;
                n_st[s].count = r_st[PREV].count;
                n_st[s].sum   = r_st[PREV].sum;
            end
            dd = {1'b0, n_st[s].sum};
            for (int k = 0; k < rafs_pkg::NDIR; k++) begin
                if (s == 0) begin
                    rin = {4'd0, i_job.weight[k]};
                end else begin
                    rin = {r_st[PREV].rem[k], 1'b0};
                end
                ge   = (rin >= dd);
                diff = rin - dd;
                n_st[s].rem[k] = ge ? diff[rafs_pkg::SUM_W-1:0] : rin[rafs_pkg::SUM_W-1:0];
                if (s == 0) begin
                    n_st[s].quo[k] = {{(rafs_pkg::Q_W-1){1'b0}}, ge};
                end else begin
                    n_st[s].quo[k] = {r_st[PREV].quo[k][rafs_pkg::Q_W-2:0], ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (en) begin
                r_v[s] <= (s == 0) ? i_job_valid : r_v[PREV];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < rafs_pkg::NDIR; k++) begin
            if (!r_st[NST-1].mask[k]) begin
                shr[k] = 16'd0;
            end else if (r_st[NST-1].quo[k][rafs_pkg::Q_W-1]) begin
                shr[k] = 16'hFFFF;
            end else begin
                shr[k] = r_st[NST-1].quo[k][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.flow_mask  <= r_st[NST-1].mask;
            r_out.flow_count <= r_st[NST-1].count;
            r_out.share_d0   <= shr[0];
            r_out.share_d1   <= shr[1];
            r_out.share_d2   <= shr[2];
            r_out.share_d3   <= shr[3];
            r_out.share_d4   <= shr[4];
            r_out.share_d5   <= shr[5];
            r_out.share_d6   <= shr[6];
            r_out.share_d7   <= shr[7];
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

// ===== src/repose_angle_flow_split.sv =====
// ----------------------------------------------------------------------------
// repose_angle_flow_split
// per-cell flow mask, count and normalized shares for thermal erosion
// path from input transaction to output valid: 2 classify registers, the queue,
// 17 division stages one quotient bit each, 1 output register
// throughput: one transaction per cycle while output is taken and not held off
// reset: config returns to defaults, pipeline and queue empty; input is held
// off after reset or a config write while thresholds settle
// ----------------------------------------------------------------------------
module repose_angle_flow_split (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output logic                o_cfg_ready,
    input  logic                i_valid,
    input  rafs_pkg::t_in_item  i_data,
    output logic                o_ready,
    output logic                o_valid,
    output rafs_pkg::t_out_item o_data,
    input  logic                i_ready
);

    logic           f_valid;
    rafs_pkg::t_job f_job;
    logic           f_ready;
    logic           q_valid;
    rafs_pkg::t_job q_job;
    logic           q_ready;

    assign o_cfg_ready = 1'b1;

    rafs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_ready     (o_ready),
        .o_job_valid (f_valid),
        .o_job       (f_job),
        .i_job_ready (f_ready)
    );

    rafs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push_data  (f_job),
        .o_push_ready (f_ready),
        .o_pop_valid  (q_valid),
        .o_pop_data   (q_job),
        .i_pop_ready  (q_ready)
    );

    rafs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_ready (q_ready),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_ready     (i_ready)
    );

endmodule
